[src/lphs_pkg.sv]
// Package for the linear probing hash set: payload structs, operation codes,
// controller states, command and status bundles and the key mixing constants.
// Used by every module of the block but lphs_ram; it depends on nothing.
package lphs_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int KEY_BITS_DEF    = 64;

  localparam int KEY_W         = 64;
  localparam int FUNC_W        = 2;
  localparam int ENTRY_COUNT_W = 10;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Finalizer constants of the 64-bit mixing function.
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic                     full_res;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_HASH,
    ST_PRB_WAIT,
    ST_PRB_CMP,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic hash_start;
    logic pos_load;
    logic pos_inc;
    logic ins_write;
    logic init_wr;
    logic clr_wr;
    logic sweep_clr;
    logic sweep_inc;
    logic count_clear;
    logic set_hit;
    logic set_full;
    logic resp_load;
  } dp_cmd_t;

  typedef struct packed {
    logic              hash_done;
    logic              slot_valid;
    logic              key_match;
    logic              count_zero;
    logic              count_full;
    logic              init_last;
    logic              clr_last;
    logic              out_free;
    logic [FUNC_W-1:0] func;
  } dp_status_t;

endpackage

[src/lphs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Stands alone; no package needed.
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/lphs_hash.sv]
// Iterative 64-bit key mixer built around one shared 32x32 multiplier.
// Depends on lphs_pkg for the mixing constants.
module lphs_hash import lphs_pkg::*; #(
  parameter int SLOT_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [KEY_W-1:0]     key,
  output logic                 done,
  output logic [SLOT_BITS-1:0] slot
);

  localparam logic [2:0] PH_LAST = 3'd4;

  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        sel_r, sel_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] mult_c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mixed;

  assign mult_c = sel_r ? MIX_C2 : MIX_C1;
  assign mul_a  = (phase_r == 3'd1) ? x_r[63:32] : x_r[31:0];
  assign mul_b  = (phase_r == 3'd2) ? mult_c[63:32] : mult_c[31:0];
  assign mixed  = acc_r ^ (acc_r >> MIX_SHIFT);
  assign slot   = mixed[SLOT_BITS-1:0];
  assign done   = busy_r && sel_r && (phase_r == PH_LAST);

  // A 64x64 product modulo 2^64 is the low-by-low product plus the low
  // halves of the two cross products added into the upper word.
  always_comb begin
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    sel_nxt   = sel_r;
    busy_nxt  = busy_r;
    prod_nxt  = mul_a * mul_b;
    if (start) begin
      x_nxt     = key ^ (key >> MIX_SHIFT);
      phase_nxt = 3'd0;
      sel_nxt   = 1'b0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      case (phase_r)
        3'd0: begin
          phase_nxt = 3'd1;
        end
        3'd1: begin
          acc_nxt   = prod_r;
          phase_nxt = 3'd2;
        end
        3'd2, 3'd3: begin
          acc_nxt[63:32] = acc_r[63:32] + prod_r[31:0];
          phase_nxt      = phase_r + 3'd1;
        end
        PH_LAST: begin
          x_nxt     = mixed;
          phase_nxt = 3'd0;
          if (sel_r) begin
            busy_nxt = 1'b0;
          end else begin
            sel_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
      sel_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sel_r   <= sel_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

endmodule

[src/lphs_dp.sv]
// Datapath: slot table and occupied list memories, probe position, counters,
// the key mixer and the result register. Depends on lphs_pkg, lphs_ram and
// lphs_hash.
module lphs_dp import lphs_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_status_t sts,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int SB = $clog2(TABLE_SLOTS);
  localparam logic [SB-1:0] KEY_LIMIT = SB'(TABLE_SLOTS / 2);

  logic [FUNC_W-1:0]   func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SB-1:0]       pos_r, pos_nxt;
  logic [SB-1:0]       count_r, count_nxt;
  logic [SB-1:0]       sweep_r, sweep_nxt;
  logic                hit_r, full_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                hash_done;
  logic [SB-1:0]       hash_slot;

  logic                slot_we;
  logic [SB-1:0]       slot_waddr;
  logic [KEY_BITS:0]   slot_wdata;
  logic [KEY_BITS:0]   slot_rdata;
  logic [SB-1:0]       occ_rdata;

  lphs_hash #(.SLOT_BITS(SB)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_start),
    .key   (KEY_W'(key_r)),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  // Each slot word carries its valid flag above the key.
  lphs_ram #(.WIDTH(KEY_BITS + 1), .DEPTH(TABLE_SLOTS)) u_slot_mem (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (pos_r),
    .rdata (slot_rdata)
  );

  lphs_ram #(.WIDTH(SB), .DEPTH(TABLE_SLOTS / 2)) u_occ_mem (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (count_r[SB-2:0]),
    .wdata (pos_r),
    .raddr (sweep_r[SB-2:0]),
    .rdata (occ_rdata)
  );

  always_comb begin
    slot_we    = cmd.init_wr || cmd.clr_wr || cmd.ins_write;
    slot_waddr = pos_r;
    slot_wdata = {1'b1, key_r};
    if (cmd.init_wr) begin
      slot_waddr = sweep_r;
      slot_wdata = '0;
    end else if (cmd.clr_wr) begin
      slot_waddr = occ_rdata;
      slot_wdata = '0;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.pos_load) begin
      pos_nxt = hash_slot;
    end else if (cmd.pos_inc) begin
      pos_nxt = pos_r + SB'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_clear) begin
      count_nxt = '0;
    end else if (cmd.ins_write) begin
      count_nxt = count_r + SB'(1);
    end
    sweep_nxt = sweep_r;
    if (cmd.sweep_clr) begin
      sweep_nxt = '0;
    end else if (cmd.sweep_inc || cmd.init_wr) begin
      sweep_nxt = sweep_r + SB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sweep_r <= sweep_nxt;
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.take) begin
      func_r <= in_data.func;
      key_r  <= in_data.key[KEY_BITS-1:0];
      hit_r  <= 1'b0;
      full_r <= 1'b0;
    end else begin
      if (cmd.set_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.set_full) begin
        full_r <= 1'b1;
      end
    end
    if (cmd.resp_load) begin
      out_data_r.hit         <= hit_r;
      out_data_r.full_res    <= full_r;
      out_data_r.entry_count <= ENTRY_COUNT_W'(count_r);
    end
  end

  assign sts.hash_done  = hash_done;
  assign sts.slot_valid = slot_rdata[KEY_BITS];
  assign sts.key_match  = (slot_rdata[KEY_BITS-1:0] == key_r);
  assign sts.count_zero = (count_r == '0);
  assign sts.count_full = (count_r == KEY_LIMIT);
  assign sts.init_last  = &sweep_r;
  assign sts.clr_last   = ((sweep_r + SB'(1)) == count_r);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.func       = func_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/lphs_ctrl.sv]
// Controller state machine: reset sweep, hashing, probe walk, clear walk and
// result hand-off. Depends on lphs_pkg for states and command/status bundles.
module lphs_ctrl import lphs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.func)
          FUNC_INSERT, FUNC_QUERY: begin
            cmd.hash_start = 1'b1;
            state_nxt      = ST_HASH;
          end
          FUNC_CLEAR: begin
            cmd.sweep_clr = 1'b1;
            state_nxt     = sts.count_zero ? ST_RESP : ST_CLR_RD;
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_HASH: begin
        if (sts.hash_done) begin
          cmd.pos_load = 1'b1;
          state_nxt    = ST_PRB_WAIT;
        end
      end
      ST_PRB_WAIT: begin
        state_nxt = ST_PRB_CMP;
      end
      ST_PRB_CMP: begin
        if (!sts.slot_valid) begin
          // Empty slot ends the walk: the key is absent.
          if (sts.func == FUNC_INSERT) begin
            if (sts.count_full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.ins_write = 1'b1;
              cmd.set_hit   = 1'b1;
            end
          end
          state_nxt = ST_RESP;
        end else if (sts.key_match) begin
          cmd.set_hit = (sts.func == FUNC_QUERY);
          state_nxt   = ST_RESP;
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = ST_PRB_WAIT;
        end
      end
      ST_CLR_RD: begin
        state_nxt = ST_CLR_WR;
      end
      ST_CLR_WR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          cmd.count_clear = 1'b1;
          state_nxt       = ST_RESP;
        end else begin
          cmd.sweep_inc = 1'b1;
          state_nxt     = ST_CLR_RD;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/linear_probe_hash_set.sv]
// Linear probing hash set: insert, membership query and clear over a table of TABLE_SLOTS.
// Insert and query: the key is mixed on the mixer's shared 32x32 multiplier, then slots
// are probed from the home slot onward, each probe a read and a compare.
// Clear empties the slot of each key held; any other code answers with no table access.
// One transaction at a time; a waiting result sits in the output register meanwhile.
// After reset the slot table is swept empty with in_ready low.
module linear_probe_hash_set_unit import lphs_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  lphs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lphs_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  a_insert_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |-> !sts.slot_valid)
    else $error("insert overwrote an occupied slot");

  a_insert_under_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |-> !sts.count_full)
    else $error("insert past half the table");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.full_res) |-> !out_data.hit)
    else $error("refused insert reported as added");

endmodule

[bench/linear_probe_hash_set_unit_tb.sv]
// Self-checking testbench for linear_probe_hash_set_unit: directed and random insert,
// query and clear traffic with random stalls on both valid/ready channels.
// Depends on lphs_pkg and the block's RTL only.
module linear_probe_hash_set_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lphs_pkg::*;

  localparam int          SLOTS        = TABLE_SLOTS_DEF;
  localparam int          HALF_SLOTS   = SLOTS / 2;
  localparam logic [63:0] KEY_MASK     = {64{1'b1}} >> (64 - KEY_BITS_DEF);
  // Drain margin; a clear of a half-full set walks all HALF_SLOTS held keys.
  localparam int          DRAIN_CYCLES = 2 * SLOTS + 100;
  // The one operation code the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

  // Keeps its own copy of the hash set and the answers still owed by the block.
  class set_scoreboard;
    bit          slot_used[SLOTS];
    logic [63:0] slot_keys[SLOTS];
    int unsigned listed_slots[HALF_SLOTS];
    int unsigned held;
    out_item_t   expected_answers[$];
    int          mismatches;

    function logic [63:0] mix64(logic [63:0] k);
      k ^= k >> MIX_SHIFT;
      k = k * MIX_C1;
      k ^= k >> MIX_SHIFT;
      k = k * MIX_C2;
      k ^= k >> MIX_SHIFT;
      return k;
    endfunction

    // Linear probe from the home slot; stops on the key or the first empty slot.
    function bit locate(logic [63:0] k, output int unsigned slot);
      int unsigned pos;
      pos = 32'(mix64(k) & 64'(SLOTS - 1));
      repeat (SLOTS) begin
        if (!slot_used[pos]) begin
          slot = pos;
          return 1'b0;
        end
        if (slot_keys[pos] == k) begin
          slot = pos;
          return 1'b1;
        end
        pos = (pos + 1) % SLOTS;
      end
      slot = pos;
      return 1'b0;
    endfunction

    function out_item_t apply_set_op(in_item_t item);
      out_item_t   res;
      logic [63:0] k;
      int unsigned slot;
      res = '0;
      k = item.key & KEY_MASK;
      case (item.func)
        FUNC_INSERT: begin
          if (!locate(k, slot)) begin
            if (held >= HALF_SLOTS) begin
              res.full_res = 1'b1;
            end else begin
              slot_used[slot] = 1'b1;
              slot_keys[slot] = k;
              listed_slots[held] = slot;
              held++;
              res.hit = 1'b1;
            end
          end
        end
        FUNC_QUERY: begin
          if (held != 0) res.hit = locate(k, slot);
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < held; i++) slot_used[listed_slots[i]] = 1'b0;
          held = 0;
        end
        default: ;
      endcase
      res.entry_count = ENTRY_COUNT_W'(held);
      return res;
    endfunction

    function void note_request(in_item_t item);
      expected_answers.insert(expected_answers.size(), apply_set_op(item));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result hit=%0b full_res=%0b entry_count=%0d", $time,
                 got.hit, got.full_res, got.entry_count);
        mismatches++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
        mismatches++;
      end
      if (got.full_res !== want.full_res) begin
        $display("%0t: full_res expected %0b actual %0b", $time, want.full_res, got.full_res);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                 got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  set_scoreboard sb;
  logic [63:0]   key_pool[$];
  bit            send_burst;
  bit            recv_burst;

  linear_probe_hash_set_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Now and then a side switches into a stretch with no idle cycles at all.
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [63:0] fresh_key();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return 64'($urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pool_key();
    if (key_pool.size() == 0) return fresh_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [63:0] k);
    in_item_t item;
    int       gap;
    item.func = f;
    item.key  = k;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_request(item);
    if (f == FUNC_INSERT) key_pool.insert(key_pool.size(), k);
    if (f == FUNC_CLEAR && $urandom_range(0, 1) == 0) key_pool.delete();
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) send_op(FUNC_INSERT, ($urandom_range(0, 9) < 3) ? pool_key() : fresh_key());
    else if (r < 88) send_op(FUNC_QUERY, ($urandom_range(0, 9) < 6) ? pool_key() : fresh_key());
    else if (r < 94) send_op(FUNC_CLEAR, {$urandom, $urandom});
    else send_op(FUNC_RESERVED, {$urandom, $urandom});
  endtask

  // Result side: random stalls, one transaction checked per handshake.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty set, zero and all-ones keys, duplicates, unused code, clears.
    send_op(FUNC_QUERY, 64'd0);
    send_op(FUNC_INSERT, 64'd0);
    send_op(FUNC_INSERT, 64'd0);
    send_op(FUNC_QUERY, 64'd0);
    send_op(FUNC_INSERT, {64{1'b1}});
    send_op(FUNC_QUERY, {64{1'b1}});
    send_op(FUNC_QUERY, 64'd1);
    send_op(FUNC_INSERT, 64'h8000_0000_0000_0000);
    send_op(FUNC_INSERT, 64'd1);
    send_op(FUNC_RESERVED, {64{1'b1}});
    send_op(FUNC_RESERVED, 64'd0);
    send_op(FUNC_QUERY, 64'd1);
    send_op(FUNC_CLEAR, 64'h5555_5555_5555_5555);
    send_op(FUNC_QUERY, 64'd0);
    send_op(FUNC_CLEAR, {64{1'b1}});
    send_op(FUNC_INSERT, 64'h5555_5555_5555_5555);
    send_op(FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(FUNC_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(FUNC_QUERY, 64'h5555_5555_5555_5555);

    repeat (150) random_op();

    // Fill the set to its bound, then hit it with new keys, duplicates and queries.
    send_op(FUNC_CLEAR, 64'd0);
    key_pool.delete();
    while (sb.held < HALF_SLOTS) begin
      if ($urandom_range(0, 7) == 0) send_op(FUNC_QUERY, pool_key());
      else send_op(FUNC_INSERT, {$urandom, $urandom});
    end
    repeat (30) begin
      case ($urandom_range(0, 2))
        0: send_op(FUNC_INSERT, {$urandom, $urandom});
        1: send_op(FUNC_INSERT, pool_key());
        default: send_op(FUNC_QUERY, pool_key());
      endcase
    end
    send_op(FUNC_CLEAR, {$urandom, $urandom});
    repeat (10) send_op(FUNC_QUERY, pool_key());

    repeat (60) random_op();

    in_valid <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
